@@ design/tdpt_pkg.sv @@
`timescale 1ns / 1ps
// Package for the trial division prime test block.
// Holds the default operand width used by the design and the testbench; no dependencies.
package tdpt_pkg;

  localparam int unsigned ValueBitsDefault = 31;

endpackage

@@ design/trial_division_prime_test.sv @@
`timescale 1ns / 1ps
// Trial division prime test: one candidate word in, one verdict word out.
// Depends on tdpt_pkg for the default operand width.
//
// Usage:
//   Input channel: candidate_i with in_valid_i / in_ready_o. One word is
//   accepted per test; in_ready_o is high only while the sequencer is idle.
//   Output channel: prime_o with out_valid_o / out_ready_i, held in an
//   output register, so a new candidate is accepted while a result waits.
//   Steps: 0, 1, 2, 3 and even values go from idle straight to the final
//   state. Odd values run trial divisors 3, 5, 7, ... while d*d <= n; each
//   trial is one restoring remainder step per bit in the shared subtractor,
//   plus a bound check and a divisor update. A prime n takes up to roughly
//   sqrt(n) / 2 trials.
//   Reset: rst_ni low clears the sequencer and the output valid; no
//   results are pending afterward.
//   Stall: if out_ready_i stays low, the result holds in the output register;
//   a finished following test waits in its final state until the register
//   frees up.
module trial_division_prime_test #(
  parameter int unsigned VALUE_BITS = tdpt_pkg::ValueBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] candidate_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  prime_o
);

  localparam int unsigned W    = VALUE_BITS;
  localparam int unsigned SqW  = W + 2;
  localparam int unsigned CntW = (W > 1) ? $clog2(W) : 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StNext  = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [W-1:0]    n_q, n_d;
  logic [W-1:0]    div_q, div_d;
  logic [SqW-1:0]  sq_q, sq_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    shift_q, shift_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            res_q, res_d;
  logic            out_valid_q, out_valid_d;
  logic            prime_q, prime_d;

  logic [W:0]      trial;
  logic            trial_ge;
  logic            in_fire;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign prime_o     = prime_q;

  assign trial    = {rem_q, shift_q[W-1]};
  assign trial_ge = (trial >= {1'b0, div_q});

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    div_d       = div_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    prime_d     = prime_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          n_d   = candidate_i;
          div_d = W'(3);
          sq_d  = SqW'(9);
          if (candidate_i < W'(2)) begin
            res_d   = 1'b0;
            state_d = StFin;
          end else if (candidate_i < W'(4)) begin
            res_d   = 1'b1;
            state_d = StFin;
          end else if (!candidate_i[0]) begin
            res_d   = 1'b0;
            state_d = StFin;
          end else begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (sq_q > {2'b00, n_q}) begin
          res_d   = 1'b1;
          state_d = StFin;
        end else begin
          rem_d   = '0;
          shift_d = n_q;
          cnt_d   = CntW'(W - 1);
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d   = trial_ge ? trial[W-1:0] - div_q : trial[W-1:0];
        shift_d = {shift_q[W-2:0], 1'b0};
        cnt_d   = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = StNext;
        end
      end
      StNext: begin
        if (rem_q == '0) begin
          res_d   = 1'b0;
          state_d = StFin;
        end else begin
          div_d   = div_q + W'(2);
          sq_d    = sq_q + {div_q, 2'b00} + SqW'(4);
          state_d = StCheck;
        end
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          prime_d     = res_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    shift_q <= shift_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    prime_q <= prime_d;
  end

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (rem_q < div_q))
    else $error("remainder not below divisor during division");

  a_div_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck || state_q == StDiv || state_q == StNext)
      |-> (div_q[0] && div_q >= W'(3)))
    else $error("trial divisor not odd or below three");

  a_even_not_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !candidate_i[0] && candidate_i != W'(2)) |=> (state_q == StFin && !res_q))
    else $error("even candidate not rejected at once");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(prime_q)))
    else $error("pending result overwritten");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for trial_division_prime_test: candidate words in, verdicts out.
// Depends on tdpt_pkg and the design; predicts each verdict by its own trial division.
module tb_top;

  localparam int unsigned ValueBits  = tdpt_pkg::ValueBitsDefault;
  localparam int unsigned CalmTail   = 150;
  localparam int unsigned StuckLimit = 3_000_000;
  localparam int unsigned DrainWait  = 40;

  typedef logic [ValueBits-1:0] cand_t;

  typedef struct packed {
    cand_t candidate;
    logic  prime;
  } verdict_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  cand_t candidate_i = '0;
  logic  out_ready_i = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  logic  prime_o;

  cand_t    pending_candidates[$];
  verdict_t pending_verdicts[$];

  int unsigned total_words  = 0;
  int unsigned sent_words   = 0;
  int unsigned seen_words   = 0;
  int unsigned prime_words  = 0;
  int unsigned error_count  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;
  cand_t       widest_value = '0;
  logic        calm;

  trial_division_prime_test #(
    .VALUE_BITS(ValueBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .candidate_i(candidate_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .prime_o    (prime_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic prime_by_division(cand_t value);
    longint unsigned n;
    longint unsigned d;
    n = 64'(value);
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Wide values always carry a factor below 16 so the search stays short.
  function automatic cand_t wide_composite();
    int unsigned factor;
    int unsigned limit;
    factor = 0;
    limit = 32'h7FFF_FFFF;
    case ($urandom_range(0, 5))
      0: factor = 3;
      1: factor = 5;
      2: factor = 7;
      3: factor = 11;
      4: factor = 13;
      default: factor = 0;
    endcase
    if (factor == 0) return cand_t'($urandom() & 32'h7FFF_FFFE);
    return cand_t'(factor * $urandom_range(1, limit / factor));
  endfunction

  function automatic cand_t random_candidate();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) return cand_t'($urandom_range(0, 255));
    if (pick < 13) return cand_t'($urandom_range(0, 4095));
    if (pick < 15) return cand_t'($urandom_range(0, 65535));
    return wide_composite();
  endfunction

  assign calm = (sent_words + CalmTail >= total_words) ||
                (sent_words >= 500 && sent_words < 600);

  // Driver: hold the word until accepted, then either idle a burst or send the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      candidate_i <= '0;
      send_gap    <= 0;
    end else if (in_valid_i && !in_ready_o) begin
      in_valid_i <= 1'b1;
    end else begin
      if (in_valid_i) begin
        pending_verdicts.push_back('{candidate_i, prime_by_division(candidate_i)});
        sent_words <= sent_words + 1;
        if (candidate_i > widest_value) widest_value <= candidate_i;
      end
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_candidates.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        send_gap   <= $urandom_range(0, 14);
        in_valid_i <= 1'b0;
      end else begin
        candidate_i <= pending_candidates.pop_front();
        in_valid_i  <= 1'b1;
      end
    end
  end

  // Monitor: compare each word against the oldest verdict, then drive ready stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen_words <= seen_words + 1;
        if (prime_o) prime_words <= prime_words + 1;
        if (pending_verdicts.size() == 0) begin
          $error("prime_o: no word expected, actual %0b", prime_o);
          error_count <= error_count + 1;
        end else begin
          want = pending_verdicts.pop_front();
          if (prime_o !== want.prime) begin
            $error("prime_o: expected %0b, actual %0b (candidate %0d)",
                   want.prime, prime_o, want.candidate);
            error_count <= error_count + 1;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall  <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        recv_stall  <= $urandom_range(0, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StuckLimit) begin
        $display("Timeout: no handshake for %0d cycles", StuckLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    cand_t edge_values[$];
    edge_values = '{0, 1, 2, 3, 4, 5, 6, 9, 15, 25, 49, 121, 169, 961, 997, 7919,
                    64507, 65521, 31'h4000_0000, 31'h5555_5555, 31'd2147483643,
                    31'h7FFF_FFFE, 31'h7FFF_FFFF};
    foreach (edge_values[i]) pending_candidates.push_back(edge_values[i]);
    repeat (1225) pending_candidates.push_back(random_candidate());
    total_words = pending_candidates.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (sent_words < total_words || pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Checked %0d of %0d candidates: %0d prime, widest value %0d.",
             seen_words, total_words, prime_words, widest_value);
    $display("Edge values, short and wide composite words, bursty stalls on both sides.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/tdpt_pkg.sv
design/trial_division_prime_test.sv
sim/tb_top.sv
